@@ sv/csih_pkg.sv @@
package csih_pkg;

  localparam int SET_IDX_W  = 10;  // width of the result index
  localparam int HI_W       = 40;  // upper address bits the IPOLY taps reach
  localparam int MODE_W     = 2;
  localparam int SETS_W     = 4;
  localparam int OFF_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int TAP_ROWS   = 49;
  localparam int TAP_SEL_W  = 6;

  typedef enum logic [MODE_W-1:0] {
    HASH_LINEAR = 2'd0,
    HASH_XOR    = 2'd1,
    HASH_IPOLY  = 2'd2,
    HASH_FIXED  = 2'd3
  } hash_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HASH_MODE  = 2'd0,
    CFG_SET_LOG2   = 2'd1,
    CFG_OFFSET     = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    hash_mode_t          hash_mode;
    logic [SETS_W-1:0]   set_count_log2;
    logic [OFF_W-1:0]    offset_bits;
  } hash_cfg_t;

  localparam hash_mode_t        RST_HASH_MODE = HASH_LINEAR;
  localparam logic [SETS_W-1:0] RST_SET_LOG2  = 4'd5;
  localparam logic [OFF_W-1:0]  RST_OFFSET    = 5'd7;

  // fixed-bit xor mode address taps
  localparam int FIX_IDX_BITS = 5;
  localparam int FIX_B0 = 13;
  localparam int FIX_B1 = 14;
  localparam int FIX_B2 = 15;
  localparam int FIX_B3 = 17;
  localparam int FIX_B4 = 19;
  localparam int FIX_B5 = 12;

  function automatic logic [HI_W-1:0] tap(int k);
    return HI_W'(1) << k;
  endfunction

  // first tap row for each index width (valid for 4..10)
  localparam logic [TAP_SEL_W-1:0] IPOLY_BASE [16] = '{
    6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd4, 6'd9, 6'd15,
    6'd22, 6'd30, 6'd39, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0
  };

  localparam logic [HI_W-1:0] IPOLY_TAPS [TAP_ROWS] = '{
    // 16 sets
    tap(11)|tap(10)|tap(9)|tap(8)|tap(6)|tap(4)|tap(3)|tap(0),
    tap(12)|tap(8)|tap(7)|tap(6)|tap(5)|tap(3)|tap(1)|tap(0),
    tap(9)|tap(8)|tap(7)|tap(6)|tap(4)|tap(2)|tap(1),
    tap(10)|tap(9)|tap(8)|tap(7)|tap(5)|tap(3)|tap(2),
    // 32 sets
    tap(13)|tap(12)|tap(11)|tap(10)|tap(9)|tap(6)|tap(5)|tap(3)|tap(0),
    tap(14)|tap(13)|tap(12)|tap(11)|tap(10)|tap(7)|tap(6)|tap(4)|tap(1),
    tap(14)|tap(10)|tap(9)|tap(8)|tap(7)|tap(6)|tap(3)|tap(2)|tap(0),
    tap(11)|tap(10)|tap(9)|tap(8)|tap(7)|tap(4)|tap(3)|tap(1),
    tap(12)|tap(11)|tap(10)|tap(9)|tap(8)|tap(5)|tap(4)|tap(2),
    // 64 sets
    tap(18)|tap(17)|tap(16)|tap(15)|tap(12)|tap(10)|tap(6)|tap(5)|tap(0),
    tap(15)|tap(13)|tap(12)|tap(11)|tap(10)|tap(7)|tap(5)|tap(1)|tap(0),
    tap(16)|tap(14)|tap(13)|tap(12)|tap(11)|tap(8)|tap(6)|tap(2)|tap(1),
    tap(17)|tap(15)|tap(14)|tap(13)|tap(12)|tap(9)|tap(7)|tap(3)|tap(2),
    tap(18)|tap(16)|tap(15)|tap(14)|tap(13)|tap(10)|tap(8)|tap(4)|tap(3),
    tap(17)|tap(16)|tap(15)|tap(14)|tap(11)|tap(9)|tap(5)|tap(4),
    // 128 sets
    tap(12)|tap(11)|tap(10)|tap(9)|tap(8)|tap(7)|tap(6)|tap(3)|tap(0),
    tap(13)|tap(12)|tap(11)|tap(10)|tap(9)|tap(8)|tap(7)|tap(4)|tap(1),
    tap(14)|tap(13)|tap(12)|tap(11)|tap(10)|tap(9)|tap(8)|tap(5)|tap(2),
    tap(15)|tap(14)|tap(13)|tap(12)|tap(11)|tap(10)|tap(9)|tap(6)|tap(3)|tap(0),
    tap(16)|tap(15)|tap(14)|tap(13)|tap(12)|tap(11)|tap(10)|tap(7)|tap(4)|tap(1),
    tap(17)|tap(16)|tap(15)|tap(14)|tap(13)|tap(12)|tap(11)|tap(8)|tap(5)|tap(2),
    tap(18)|tap(17)|tap(16)|tap(15)|tap(14)|tap(13)|tap(12)|tap(9)|tap(6)|tap(3),
    // 256 sets
    tap(19)|tap(18)|tap(17)|tap(15)|tap(13)|tap(12)|tap(10)|tap(7)|tap(4)|tap(3)
      |tap(2)|tap(0),
    tap(20)|tap(19)|tap(18)|tap(16)|tap(14)|tap(13)|tap(11)|tap(8)|tap(5)|tap(4)
      |tap(3)|tap(1),
    tap(21)|tap(20)|tap(19)|tap(17)|tap(15)|tap(14)|tap(12)|tap(9)|tap(6)|tap(5)
      |tap(4)|tap(2),
    tap(22)|tap(21)|tap(20)|tap(18)|tap(16)|tap(15)|tap(13)|tap(10)|tap(7)|tap(6)
      |tap(5)|tap(3),
    tap(23)|tap(22)|tap(21)|tap(19)|tap(17)|tap(16)|tap(14)|tap(11)|tap(8)|tap(7)
      |tap(6)|tap(4)|tap(0),
    tap(24)|tap(23)|tap(22)|tap(20)|tap(18)|tap(17)|tap(15)|tap(12)|tap(9)|tap(8)
      |tap(7)|tap(5)|tap(1),
    tap(25)|tap(24)|tap(23)|tap(21)|tap(19)|tap(18)|tap(16)|tap(13)|tap(10)|tap(9)
      |tap(8)|tap(6)|tap(2),
    tap(26)|tap(25)|tap(24)|tap(22)|tap(20)|tap(19)|tap(17)|tap(14)|tap(11)|tap(10)
      |tap(9)|tap(7)|tap(3),
    // 512 sets
    tap(25)|tap(23)|tap(22)|tap(21)|tap(19)|tap(17)|tap(15)|tap(12)|tap(8)|tap(4)
      |tap(0),
    tap(26)|tap(24)|tap(23)|tap(22)|tap(20)|tap(18)|tap(16)|tap(13)|tap(9)|tap(5)
      |tap(1),
    tap(27)|tap(25)|tap(24)|tap(23)|tap(21)|tap(19)|tap(17)|tap(14)|tap(10)|tap(6)
      |tap(2),
    tap(28)|tap(26)|tap(25)|tap(24)|tap(22)|tap(20)|tap(18)|tap(15)|tap(11)|tap(7)
      |tap(3),
    tap(29)|tap(27)|tap(26)|tap(25)|tap(23)|tap(21)|tap(19)|tap(16)|tap(12)|tap(8)
      |tap(4)|tap(0),
    tap(30)|tap(28)|tap(27)|tap(26)|tap(24)|tap(22)|tap(20)|tap(17)|tap(13)|tap(9)
      |tap(5)|tap(1),
    tap(31)|tap(29)|tap(28)|tap(27)|tap(25)|tap(23)|tap(21)|tap(18)|tap(14)|tap(10)
      |tap(6)|tap(2),
    tap(32)|tap(30)|tap(29)|tap(28)|tap(26)|tap(24)|tap(22)|tap(19)|tap(15)|tap(11)
      |tap(7)|tap(3),
    tap(33)|tap(31)|tap(30)|tap(29)|tap(27)|tap(25)|tap(23)|tap(20)|tap(16)|tap(12)
      |tap(8)|tap(4),
    // 1024 sets
    tap(30)|tap(28)|tap(27)|tap(26)|tap(24)|tap(22)|tap(20)|tap(18)|tap(16)|tap(12)
      |tap(9)|tap(3)|tap(0),
    tap(31)|tap(29)|tap(28)|tap(27)|tap(25)|tap(23)|tap(21)|tap(19)|tap(17)|tap(13)
      |tap(10)|tap(4)|tap(1),
    tap(32)|tap(30)|tap(29)|tap(28)|tap(26)|tap(24)|tap(22)|tap(20)|tap(18)|tap(14)
      |tap(11)|tap(5)|tap(2),
    tap(33)|tap(31)|tap(30)|tap(29)|tap(27)|tap(25)|tap(23)|tap(21)|tap(19)|tap(15)
      |tap(12)|tap(6)|tap(3)|tap(0),
    tap(34)|tap(32)|tap(31)|tap(30)|tap(28)|tap(26)|tap(24)|tap(22)|tap(20)|tap(16)
      |tap(13)|tap(7)|tap(4)|tap(1),
    tap(35)|tap(33)|tap(32)|tap(31)|tap(29)|tap(27)|tap(25)|tap(23)|tap(21)|tap(17)
      |tap(14)|tap(8)|tap(5)|tap(2),
    tap(36)|tap(34)|tap(33)|tap(32)|tap(30)|tap(28)|tap(26)|tap(24)|tap(22)|tap(18)
      |tap(15)|tap(9)|tap(6)|tap(3),
    tap(37)|tap(35)|tap(34)|tap(33)|tap(31)|tap(29)|tap(27)|tap(25)|tap(23)|tap(19)
      |tap(16)|tap(10)|tap(7)|tap(4),
    tap(38)|tap(36)|tap(35)|tap(34)|tap(32)|tap(30)|tap(28)|tap(26)|tap(24)|tap(20)
      |tap(17)|tap(11)|tap(8)|tap(5),
    tap(39)|tap(37)|tap(36)|tap(35)|tap(33)|tap(31)|tap(29)|tap(27)|tap(25)|tap(21)
      |tap(18)|tap(12)|tap(9)|tap(6)
  };

endpackage

@@ sv/csih_addr_if.sv @@
interface csih_addr_if #(
  parameter int ADDR_WIDTH = 64
);
  logic                  valid;
  logic                  ready;
  logic [ADDR_WIDTH-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

@@ sv/csih_result_if.sv @@
interface csih_result_if;
  import csih_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [SET_IDX_W-1:0] set_index;
  logic                 config_error;

  modport source (output valid, output set_index, output config_error, input ready);
  modport sink (input valid, input set_index, input config_error, output ready);
endinterface

@@ sv/csih_hash.sv @@
module csih_hash #(
  parameter int ADDR_WIDTH   = 64,
  parameter int MAX_SET_BITS = 10
) (
  input  csih_pkg::hash_cfg_t              cfg,
  input  logic [ADDR_WIDTH-1:0]            addr,
  output logic [csih_pkg::SET_IDX_W-1:0]   set_index,
  output logic                             config_error
);
  import csih_pkg::*;

  localparam int SHAMT_W = OFF_W + 1;

  logic [ADDR_WIDTH-1:0] line;
  logic [ADDR_WIDTH-1:0] higher_full;
  logic [SHAMT_W-1:0]    hi_shamt;
  logic [SET_IDX_W-1:0]  idx;
  logic [SET_IDX_W-1:0]  imask;
  logic [HI_W-1:0]       higher;
  logic [TAP_SEL_W-1:0]  base;
  logic [SET_IDX_W-1:0]  ipoly_res;
  logic [SET_IDX_W-1:0]  fixed_res;
  logic [SETS_W-1:0]     n;

  assign n           = cfg.set_count_log2;
  assign hi_shamt    = SHAMT_W'(cfg.offset_bits) + SHAMT_W'(n);
  assign line        = addr >> cfg.offset_bits;
  assign higher_full = addr >> hi_shamt;
  assign higher      = higher_full[HI_W-1:0];
  // n above the index width leaves every mask bit set, but that case is an error
  assign imask       = ~({SET_IDX_W{1'b1}} << n);
  assign idx         = line[SET_IDX_W-1:0] & imask;
  assign base        = IPOLY_BASE[n];

  // one parity tree per index bit, rows picked by the set count
  always_comb begin
    ipoly_res = '0;
    for (int j = 0; j < SET_IDX_W; j++) begin
      if (j < int'(n)) begin
        ipoly_res[j] = (^(higher & IPOLY_TAPS[base + TAP_SEL_W'(j)])) ^ idx[j];
      end
    end
  end

  always_comb begin
    fixed_res = '0;
    fixed_res[FIX_IDX_BITS-1:0] = line[FIX_IDX_BITS-1:0]
      ^ {addr[FIX_B4], addr[FIX_B3], addr[FIX_B2], addr[FIX_B1], addr[FIX_B0]};
    if (n == SETS_W'(FIX_IDX_BITS + 1)) begin
      fixed_res[FIX_IDX_BITS] = addr[FIX_B5];
    end
  end

  always_comb begin
    set_index    = '0;
    config_error = 1'b0;
    if (int'(n) > MAX_SET_BITS) begin
      config_error = 1'b1;
    end else begin
      unique case (cfg.hash_mode)
        HASH_LINEAR: set_index = idx;
        HASH_XOR:    set_index = idx ^ (higher[SET_IDX_W-1:0] & imask);
        HASH_IPOLY: begin
          if (n < SETS_W'(4) || n > SETS_W'(SET_IDX_W)) begin
            config_error = 1'b1;
          end else begin
            set_index = ipoly_res;
          end
        end
        HASH_FIXED: begin
          if (n != SETS_W'(FIX_IDX_BITS) && n != SETS_W'(FIX_IDX_BITS + 1)) begin
            config_error = 1'b1;
          end else begin
            set_index = fixed_res;
          end
        end
        default: config_error = 1'b1;
      endcase
    end
  end

endmodule

@@ sv/cache_set_index_hash_unit.sv @@
// Pipeline: the accepted address is held in the input register, the hash logic works
//   on it combinationally, and the result register presents the set index and error flag.
// Throughput: one address per cycle; both registers advance together while the
//   result side takes data, so the hash path between them sets the clock.
// Reset: synchronous active-low rst_n empties the pipe and loads the config
//   registers with linear mode, 32 sets and 7 offset bits.
module cache_set_index_hash_unit #(
  parameter int ADDR_WIDTH   = 64,
  parameter int MAX_SET_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  csih_addr_if.sink                       in_chan,
  csih_result_if.source                   out_chan,
  input  logic                            cfg_we,
  input  logic [csih_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csih_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import csih_pkg::*;

  hash_cfg_t             cfg_r;
  logic                  v1_r;
  logic                  v2_r;
  logic [ADDR_WIDTH-1:0] addr_r;
  logic [SET_IDX_W-1:0]  set_index_r;
  logic                  config_error_r;
  logic [SET_IDX_W-1:0]  set_index_nxt;
  logic                  config_error_nxt;
  logic                  adv2;
  logic                  in_take;

  assign adv2          = !v2_r || out_chan.ready;
  assign in_chan.ready = !v1_r || adv2;
  assign in_take       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hash_mode      <= RST_HASH_MODE;
      cfg_r.set_count_log2 <= RST_SET_LOG2;
      cfg_r.offset_bits    <= RST_OFFSET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_HASH_MODE: cfg_r.hash_mode      <= hash_mode_t'(cfg_wdata[MODE_W-1:0]);
        CFG_SET_LOG2:  cfg_r.set_count_log2 <= cfg_wdata[SETS_W-1:0];
        CFG_OFFSET:    cfg_r.offset_bits    <= cfg_wdata[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  csih_hash #(
    .ADDR_WIDTH   (ADDR_WIDTH),
    .MAX_SET_BITS (MAX_SET_BITS)
  ) u_hash (
    .cfg          (cfg_r),
    .addr         (addr_r),
    .set_index    (set_index_nxt),
    .config_error (config_error_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (in_take) begin
        v1_r <= 1'b1;
      end else if (adv2) begin
        v1_r <= 1'b0;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      addr_r <= in_chan.address;
    end
    if (adv2 && v1_r) begin
      set_index_r    <= set_index_nxt;
      config_error_r <= config_error_nxt;
    end
  end

  assign out_chan.valid        = v2_r;
  assign out_chan.set_index    = set_index_r;
  assign out_chan.config_error = config_error_r;

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> (!v1_r && !v2_r))
    else $error("pipeline not empty after reset");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && config_error_r) |-> (set_index_r == '0))
    else $error("error result carries a nonzero index");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !config_error_r) |-> ((set_index_r >> cfg_r.set_count_log2) == '0))
    else $error("index not below the set count");

  a_ipoly_err: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && cfg_r.hash_mode == HASH_IPOLY
      && (cfg_r.set_count_log2 < SETS_W'(4) || cfg_r.set_count_log2 > SETS_W'(10)))
      |-> config_error_r)
    else $error("unsupported IPOLY set count not flagged");

  a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && v1_r) |-> adv2)
    else $error("input taken while first stage holds a stalled address");
`endif

endmodule

@@ sim/tb_cache_set_index_hash_unit.sv @@
`timescale 1ns / 1ps

module tb_cache_set_index_hash_unit;
  import csih_pkg::*;

  localparam int ADDR_W       = 64;
  localparam int MAX_SETS_LOG = 10;
  localparam int ITEM_TARGET  = 950;
  localparam int STALL_LIMIT  = 2000;
  localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [SET_IDX_W-1:0] set_index;
    logic                 config_error;
  } set_result_t;

  // one line of the directed table: a register write or an address
  typedef struct packed {
    logic                 wr;
    cfg_reg_t             sel;
    logic [4:0]           wdata;
    logic [63:0]          addr;
    logic                 known;
    logic [SET_IDX_W-1:0] idx;
    logic                 err;
  } dir_row_t;

  function automatic logic [39:0] hb(int k);
    return 40'd1 << k;
  endfunction

  // IPOLY equations, one row per index bit; taps are bits of the address above the index
  localparam logic [39:0] IPOLY_ROWS [49] = '{
    hb(11)|hb(10)|hb(9)|hb(8)|hb(6)|hb(4)|hb(3)|hb(0),
    hb(12)|hb(8)|hb(7)|hb(6)|hb(5)|hb(3)|hb(1)|hb(0),
    hb(9)|hb(8)|hb(7)|hb(6)|hb(4)|hb(2)|hb(1),
    hb(10)|hb(9)|hb(8)|hb(7)|hb(5)|hb(3)|hb(2),
    hb(13)|hb(12)|hb(11)|hb(10)|hb(9)|hb(6)|hb(5)|hb(3)|hb(0),
    hb(14)|hb(13)|hb(12)|hb(11)|hb(10)|hb(7)|hb(6)|hb(4)|hb(1),
    hb(14)|hb(10)|hb(9)|hb(8)|hb(7)|hb(6)|hb(3)|hb(2)|hb(0),
    hb(11)|hb(10)|hb(9)|hb(8)|hb(7)|hb(4)|hb(3)|hb(1),
    hb(12)|hb(11)|hb(10)|hb(9)|hb(8)|hb(5)|hb(4)|hb(2),
    hb(18)|hb(17)|hb(16)|hb(15)|hb(12)|hb(10)|hb(6)|hb(5)|hb(0),
    hb(15)|hb(13)|hb(12)|hb(11)|hb(10)|hb(7)|hb(5)|hb(1)|hb(0),
    hb(16)|hb(14)|hb(13)|hb(12)|hb(11)|hb(8)|hb(6)|hb(2)|hb(1),
    hb(17)|hb(15)|hb(14)|hb(13)|hb(12)|hb(9)|hb(7)|hb(3)|hb(2),
    hb(18)|hb(16)|hb(15)|hb(14)|hb(13)|hb(10)|hb(8)|hb(4)|hb(3),
    hb(17)|hb(16)|hb(15)|hb(14)|hb(11)|hb(9)|hb(5)|hb(4),
    hb(12)|hb(11)|hb(10)|hb(9)|hb(8)|hb(7)|hb(6)|hb(3)|hb(0),
    hb(13)|hb(12)|hb(11)|hb(10)|hb(9)|hb(8)|hb(7)|hb(4)|hb(1),
    hb(14)|hb(13)|hb(12)|hb(11)|hb(10)|hb(9)|hb(8)|hb(5)|hb(2),
    hb(15)|hb(14)|hb(13)|hb(12)|hb(11)|hb(10)|hb(9)|hb(6)|hb(3)|hb(0),
    hb(16)|hb(15)|hb(14)|hb(13)|hb(12)|hb(11)|hb(10)|hb(7)|hb(4)|hb(1),
    hb(17)|hb(16)|hb(15)|hb(14)|hb(13)|hb(12)|hb(11)|hb(8)|hb(5)|hb(2),
    hb(18)|hb(17)|hb(16)|hb(15)|hb(14)|hb(13)|hb(12)|hb(9)|hb(6)|hb(3),
    hb(19)|hb(18)|hb(17)|hb(15)|hb(13)|hb(12)|hb(10)|hb(7)|hb(4)|hb(3)|hb(2)|hb(0),
    hb(20)|hb(19)|hb(18)|hb(16)|hb(14)|hb(13)|hb(11)|hb(8)|hb(5)|hb(4)|hb(3)|hb(1),
    hb(21)|hb(20)|hb(19)|hb(17)|hb(15)|hb(14)|hb(12)|hb(9)|hb(6)|hb(5)|hb(4)|hb(2),
    hb(22)|hb(21)|hb(20)|hb(18)|hb(16)|hb(15)|hb(13)|hb(10)|hb(7)|hb(6)|hb(5)|hb(3),
    hb(23)|hb(22)|hb(21)|hb(19)|hb(17)|hb(16)|hb(14)|hb(11)|hb(8)|hb(7)|hb(6)|hb(4)
      |hb(0),
    hb(24)|hb(23)|hb(22)|hb(20)|hb(18)|hb(17)|hb(15)|hb(12)|hb(9)|hb(8)|hb(7)|hb(5)
      |hb(1),
    hb(25)|hb(24)|hb(23)|hb(21)|hb(19)|hb(18)|hb(16)|hb(13)|hb(10)|hb(9)|hb(8)|hb(6)
      |hb(2),
    hb(26)|hb(25)|hb(24)|hb(22)|hb(20)|hb(19)|hb(17)|hb(14)|hb(11)|hb(10)|hb(9)|hb(7)
      |hb(3),
    hb(25)|hb(23)|hb(22)|hb(21)|hb(19)|hb(17)|hb(15)|hb(12)|hb(8)|hb(4)|hb(0),
    hb(26)|hb(24)|hb(23)|hb(22)|hb(20)|hb(18)|hb(16)|hb(13)|hb(9)|hb(5)|hb(1),
    hb(27)|hb(25)|hb(24)|hb(23)|hb(21)|hb(19)|hb(17)|hb(14)|hb(10)|hb(6)|hb(2),
    hb(28)|hb(26)|hb(25)|hb(24)|hb(22)|hb(20)|hb(18)|hb(15)|hb(11)|hb(7)|hb(3),
    hb(29)|hb(27)|hb(26)|hb(25)|hb(23)|hb(21)|hb(19)|hb(16)|hb(12)|hb(8)|hb(4)|hb(0),
    hb(30)|hb(28)|hb(27)|hb(26)|hb(24)|hb(22)|hb(20)|hb(17)|hb(13)|hb(9)|hb(5)|hb(1),
    hb(31)|hb(29)|hb(28)|hb(27)|hb(25)|hb(23)|hb(21)|hb(18)|hb(14)|hb(10)|hb(6)|hb(2),
    hb(32)|hb(30)|hb(29)|hb(28)|hb(26)|hb(24)|hb(22)|hb(19)|hb(15)|hb(11)|hb(7)|hb(3),
    hb(33)|hb(31)|hb(30)|hb(29)|hb(27)|hb(25)|hb(23)|hb(20)|hb(16)|hb(12)|hb(8)|hb(4),
    hb(30)|hb(28)|hb(27)|hb(26)|hb(24)|hb(22)|hb(20)|hb(18)|hb(16)|hb(12)|hb(9)|hb(3)
      |hb(0),
    hb(31)|hb(29)|hb(28)|hb(27)|hb(25)|hb(23)|hb(21)|hb(19)|hb(17)|hb(13)|hb(10)|hb(4)
      |hb(1),
    hb(32)|hb(30)|hb(29)|hb(28)|hb(26)|hb(24)|hb(22)|hb(20)|hb(18)|hb(14)|hb(11)|hb(5)
      |hb(2),
    hb(33)|hb(31)|hb(30)|hb(29)|hb(27)|hb(25)|hb(23)|hb(21)|hb(19)|hb(15)|hb(12)|hb(6)
      |hb(3)|hb(0),
    hb(34)|hb(32)|hb(31)|hb(30)|hb(28)|hb(26)|hb(24)|hb(22)|hb(20)|hb(16)|hb(13)|hb(7)
      |hb(4)|hb(1),
    hb(35)|hb(33)|hb(32)|hb(31)|hb(29)|hb(27)|hb(25)|hb(23)|hb(21)|hb(17)|hb(14)|hb(8)
      |hb(5)|hb(2),
    hb(36)|hb(34)|hb(33)|hb(32)|hb(30)|hb(28)|hb(26)|hb(24)|hb(22)|hb(18)|hb(15)|hb(9)
      |hb(6)|hb(3),
    hb(37)|hb(35)|hb(34)|hb(33)|hb(31)|hb(29)|hb(27)|hb(25)|hb(23)|hb(19)|hb(16)|hb(10)
      |hb(7)|hb(4),
    hb(38)|hb(36)|hb(35)|hb(34)|hb(32)|hb(30)|hb(28)|hb(26)|hb(24)|hb(20)|hb(17)|hb(11)
      |hb(8)|hb(5),
    hb(39)|hb(37)|hb(36)|hb(35)|hb(33)|hb(31)|hb(29)|hb(27)|hb(25)|hb(21)|hb(18)|hb(12)
      |hb(9)|hb(6)
  };

  // starts from reset config: linear, 32 sets, 7 offset bits
  localparam dir_row_t DIRECTED [38] = '{
    '{1'b0, CFG_HASH_MODE, 5'd0, 64'h0,                1'b1, 10'd0,    1'b0},
    '{1'b0, CFG_HASH_MODE, 5'd0, ONES,                 1'b1, 10'd31,   1'b0},
    '{1'b0, CFG_HASH_MODE, 5'd0, 64'h0000_0000_0F80,   1'b1, 10'd31,   1'b0},
    '{1'b0, CFG_HASH_MODE, 5'd0, 64'h0000_0000_107F,   1'b1, 10'd0,    1'b0},
    '{1'b1, CFG_HASH_MODE, 5'(HASH_XOR), 64'h0,        1'b0, 10'd0,    1'b0},
    '{1'b0, CFG_HASH_MODE, 5'd0, ONES,                 1'b1, 10'd0,    1'b0},
    '{1'b0, CFG_HASH_MODE, 5'd0, 64'h0000_0001_2F80,   1'b0, 10'd0,    1'b0},
    '{1'b1, CFG_SET_LOG2,  5'd0, 64'h0,                1'b0, 10'd0,    1'b0},
    '{1'b0, CFG_HASH_MODE, 5'd0, ONES,                 1'b1, 10'd0,    1'b0},
    '{1'b1, CFG_HASH_MODE, 5'(HASH_IPOLY), 64'h0,      1'b0, 10'd0,    1'b0},
    '{1'b0, CFG_HASH_MODE, 5'd0, ONES,                 1'b1, 10'd0,    1'b1},
    '{1'b1, CFG_SET_LOG2,  5'd4, 64'h0,                1'b0, 10'd0,    1'b0},
    '{1'b0, CFG_HASH_MODE, 5'd0, 64'hDEAD_BEEF_CAFE_F00D, 1'b0, 10'd0, 1'b0},
    '{1'b0, CFG_HASH_MODE, 5'd0, ONES,                 1'b0, 10'd0,    1'b0},
    '{1'b1, CFG_SET_LOG2,  5'd10, 64'h0,               1'b0, 10'd0,    1'b0},
    '{1'b1, CFG_OFFSET,    5'd0, 64'h0,                1'b0, 10'd0,    1'b0},
    '{1'b0, CFG_HASH_MODE, 5'd0, ONES,                 1'b0, 10'd0,    1'b0},
    '{1'b0, CFG_HASH_MODE, 5'd0, 64'h8000_0000_0000_0000, 1'b0, 10'd0, 1'b0},
    '{1'b0, CFG_HASH_MODE, 5'd0, 64'h1,                1'b0, 10'd0,    1'b0},
    '{1'b1, CFG_SET_LOG2,  5'd11, 64'h0,               1'b0, 10'd0,    1'b0},
    '{1'b0, CFG_HASH_MODE, 5'd0, ONES,                 1'b1, 10'd0,    1'b1},
    '{1'b1, CFG_HASH_MODE, 5'(HASH_FIXED), 64'h0,      1'b0, 10'd0,    1'b0},
    '{1'b1, CFG_SET_LOG2,  5'd6, 64'h0,                1'b0, 10'd0,    1'b0},
    '{1'b1, CFG_OFFSET,    5'd16, 64'h0,               1'b0, 10'd0,    1'b0},
    '{1'b0, CFG_HASH_MODE, 5'd0, 64'h0000_0000_000F_F000, 1'b0, 10'd0, 1'b0},
    '{1'b0, CFG_HASH_MODE, 5'd0, 64'h0000_0000_1000,   1'b0, 10'd0,    1'b0},
    '{1'b1, CFG_SET_LOG2,  5'd5, 64'h0,                1'b0, 10'd0,    1'b0},
    '{1'b0, CFG_HASH_MODE, 5'd0, ONES,                 1'b0, 10'd0,    1'b0},
    '{1'b1, CFG_SET_LOG2,  5'd7, 64'h0,                1'b0, 10'd0,    1'b0},
    '{1'b0, CFG_HASH_MODE, 5'd0, ONES,                 1'b1, 10'd0,    1'b1},
    '{1'b1, CFG_HASH_MODE, 5'(HASH_LINEAR), 64'h0,     1'b0, 10'd0,    1'b0},
    '{1'b1, CFG_SET_LOG2,  5'd10, 64'h0,               1'b0, 10'd0,    1'b0},
    '{1'b1, CFG_OFFSET,    5'd31, 64'h0,               1'b0, 10'd0,    1'b0},
    '{1'b0, CFG_HASH_MODE, 5'd0, ONES,                 1'b1, 10'd1023, 1'b0},
    '{1'b1, CFG_UNUSED,    5'h1F, 64'h0,               1'b0, 10'd0,    1'b0},
    '{1'b0, CFG_HASH_MODE, 5'd0, ONES,                 1'b1, 10'd1023, 1'b0},
    '{1'b1, CFG_SET_LOG2,  5'd15, 64'h0,               1'b0, 10'd0,    1'b0},
    '{1'b0, CFG_HASH_MODE, 5'd0, ONES,                 1'b1, 10'd0,    1'b1}
  };

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  cfg_reg_t   cfg_index;
  logic [4:0] cfg_wdata;

  // typed-in expectation that travels with the address on the wire
  logic                 given_valid;
  logic [SET_IDX_W-1:0] given_index;
  logic                 given_error;

  csih_addr_if #(.ADDR_WIDTH(ADDR_W)) addr_ch ();
  csih_result_if res_ch ();

  cache_set_index_hash_unit #(
    .ADDR_WIDTH  (ADDR_W),
    .MAX_SET_BITS(MAX_SETS_LOG)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (addr_ch),
    .out_chan (res_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  set_result_t       pending_sets [$];
  hash_mode_t        cur_mode;
  logic [SETS_W-1:0] cur_sets;
  logic [OFF_W-1:0]  cur_off;
  int                fails = 0;
  int                idle_cycles = 0;
  int                items_sent = 0;
  int                cyc = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cyc <= cyc + 1;

  function automatic set_result_t hash_address(hash_mode_t mode, logic [SETS_W-1:0] sets,
                                               logic [OFF_W-1:0] off, logic [63:0] a);
    set_result_t r;
    logic [63:0] line, higher, mask, idx;
    int n, base, j;
    r = '0;
    n = sets;
    mask = (64'd1 << n) - 64'd1;
    line = a >> off;
    idx = line & mask;
    higher = a >> (int'(off) + n);
    if (n > MAX_SETS_LOG) begin
      r.config_error = 1'b1;
    end else begin
      case (mode)
        HASH_LINEAR: r.set_index = idx[SET_IDX_W-1:0];
        HASH_XOR: r.set_index = idx[SET_IDX_W-1:0] ^ higher[SET_IDX_W-1:0] & mask[9:0];
        HASH_IPOLY: begin
          if (n < 4) begin
            r.config_error = 1'b1;
          end else begin
            base = n * (n - 1) / 2 - 6;
            for (j = 0; j < n; j++)
              r.set_index[j] = (^(higher[39:0] & IPOLY_ROWS[base + j])) ^ idx[j];
          end
        end
        default: begin
          if (n != 5 && n != 6) begin
            r.config_error = 1'b1;
          end else begin
            r.set_index[4:0] = line[4:0] ^ {a[19], a[17], a[15:13]};
            if (n == 6) r.set_index[5] = a[12];
          end
        end
      endcase
    end
    return r;
  endfunction

  // mostly back-to-back, some short gaps, a few long ones; quiet windows have none
  function automatic int idle_len();
    int r;
    if (cyc % 400 < 80) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] rand_address();
    logic [63:0] a;
    a = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: a = 64'd1 << $urandom_range(0, 63);
      1: a = ~(64'd1 << $urandom_range(0, 63));
      2: a = a & 64'h0000_00FF_FFFF_FFFF;
      default: ;
    endcase
    return a;
  endfunction

  // prediction at the accepting edge, check at the result edge
  always @(posedge clk) begin : scoreboard
    set_result_t want;
    if (!rst_n) begin
      cur_mode = RST_HASH_MODE;
      cur_sets = RST_SET_LOG2;
      cur_off = RST_OFFSET;
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (addr_ch.valid && addr_ch.ready) begin
        idle_cycles = 0;
        if (given_valid) want = '{given_index, given_error};
        else want = hash_address(cur_mode, cur_sets, cur_off, addr_ch.address);
        pending_sets = {pending_sets, want};
      end
      if (res_ch.valid && res_ch.ready) begin
        idle_cycles = 0;
        if (pending_sets.size() == 0) begin
          $error("unexpected result transaction: set_index %0d config_error %0b",
                 res_ch.set_index, res_ch.config_error);
          fails++;
        end else begin
          want = pending_sets.pop_front();
          if (res_ch.set_index !== want.set_index) begin
            $error("set_index mismatch: expected %0d, actual %0d",
                   want.set_index, res_ch.set_index);
            fails++;
          end
          if (res_ch.config_error !== want.config_error) begin
            $error("config_error mismatch: expected %0b, actual %0b",
                   want.config_error, res_ch.config_error);
            fails++;
          end
        end
      end
      if (cfg_we) begin
        idle_cycles = 0;
        case (cfg_index)
          CFG_HASH_MODE: cur_mode = hash_mode_t'(cfg_wdata[MODE_W-1:0]);
          CFG_SET_LOG2:  cur_sets = cfg_wdata[SETS_W-1:0];
          CFG_OFFSET:    cur_off = cfg_wdata[OFF_W-1:0];
          default: ;
        endcase
      end
    end
  end

  initial begin : result_ready
    int hold;
    hold = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        res_ch.ready <= 1'b0;
      end else begin
        hold = idle_len();
        res_ch.ready <= (hold == 0);
        if (hold > 0) hold--;
      end
    end
  end

  initial begin : watchdog
    do @(negedge clk); while (idle_cycles < STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic push_address(input logic [63:0] a, input logic known = 1'b0,
                              input logic [SET_IDX_W-1:0] idx = '0, input logic err = 1'b0);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      addr_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    addr_ch.valid   <= 1'b1;
    addr_ch.address <= a;
    given_valid     <= known;
    given_index     <= idx;
    given_error     <= err;
    do @(posedge clk); while (!addr_ch.ready);
    items_sent++;
  endtask

  // hold off until every pending result is back and the pipe is empty
  task automatic drain_results();
    addr_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_sets.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [4:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int i, phase, r, count;
    hash_mode_t mode;
    logic [3:0] sets;
    logic [4:0] off;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_HASH_MODE;
    cfg_wdata = '0;
    addr_ch.valid = 1'b0;
    addr_ch.address = '0;
    given_valid = 1'b0;
    given_index = '0;
    given_error = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < $size(DIRECTED); i++) begin
      if (DIRECTED[i].wr) begin
        drain_results();
        write_reg(DIRECTED[i].sel, DIRECTED[i].wdata);
      end else begin
        push_address(DIRECTED[i].addr, DIRECTED[i].known, DIRECTED[i].idx, DIRECTED[i].err);
      end
    end

    // each phase: settle, reprogram, then a burst of random addresses
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      drain_results();
      mode = hash_mode_t'(phase % 4);
      r = $urandom_range(0, 9);
      if (r == 0) sets = 4'($urandom_range(11, 15));
      else if (mode == HASH_FIXED && r < 8) sets = 4'(5 + r % 2);
      else sets = 4'((phase / 4) % 11);
      r = $urandom_range(0, 7);
      off = (r == 0) ? 5'd0 : (r == 1) ? 5'd31 : (r == 2) ? 5'd16 : 5'($urandom_range(0, 31));
      write_reg(CFG_HASH_MODE, {3'($urandom), mode});
      write_reg(CFG_SET_LOG2, {1'($urandom), sets});
      write_reg(CFG_OFFSET, off);
      if (phase % 5 == 2) write_reg(CFG_UNUSED, 5'($urandom));
      count = $urandom_range(8, 32);
      repeat (count) push_address(rand_address());
      phase++;
    end

    addr_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_sets.size() != 0);
    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
